/* rtl/core/cdse_pkg.sv */
`default_nettype none
package cdse_pkg;
	localparam int WAVE_LEN_DEF    = 512;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int WIN_W           = 9;
	localparam int IDX_W           = 9;
	localparam int SLOPE_W         = 21;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 9'd16;

	typedef enum logic {
		REG_SLOPE_WINDOW = 1'b0,
		REG_PULSER_MODE  = 1'b1
	} reg_index_t;

	// Job handed from the front end to the fit engine when a waveform ends.
	typedef struct packed {
		logic             clipped;
		logic [IDX_W-1:0] clip_index;
		logic             fit_req;
		logic [IDX_W-1:0] fit_lo;
		logic [IDX_W:0]   fit_n;
		logic             wave_sel;
	} cdse_job_t;

	typedef enum logic [2:0] {
		FIT_IDLE,
		FIT_ACC,
		FIT_MUL,
		FIT_DIV,
		FIT_OUT
	} fit_state_t;
endpackage
`default_nettype wire

/* rtl/core/cdse_ram.sv */
`default_nettype none
module cdse_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* rtl/core/cdse_front.sv */
`default_nettype none
module cdse_front #(
	parameter int WAVE_LEN    = cdse_pkg::WAVE_LEN_DEF,
	parameter int SAMPLE_BITS = cdse_pkg::SAMPLE_BITS_DEF,
	parameter int AW          = $clog2(WAVE_LEN) + 1
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_fire,
	input  wire [SAMPLE_BITS-1:0]        sample,
	input  wire                          inverted,
	input  wire                          first_sample,
	input  wire                          last_sample,
	input  wire [cdse_pkg::WIN_W-1:0]    slope_window,
	input  wire                          pulser_mode,
	output logic                         wr_en,
	output logic [AW-1:0]                wr_addr,
	output logic [SAMPLE_BITS-1:0]       wr_data,
	output logic                         job_push,
	output cdse_pkg::cdse_job_t          job
);
	import cdse_pkg::*;
	localparam int CW = $clog2(WAVE_LEN + 1);
	localparam logic [SAMPLE_BITS-1:0] FULL = {SAMPLE_BITS{1'b1}};

	logic [CW-1:0]    index_q;
	logic             clip_q;
	logic [IDX_W-1:0] clip_pos_q;
	logic             fit_q;
	logic [IDX_W-1:0] lo_q;
	logic [IDX_W:0]   n_q;
	logic             sel_q;

	logic [CW-1:0]    idx;
	logic             clip_c, in_range, hit;
	logic [IDX_W-1:0] lo_c;
	logic [IDX_W:0]   n_c;
	logic [CW:0]      win_ext;

	always_comb begin
		idx      = first_sample ? '0 : index_q;
		clip_c   = first_sample ? 1'b0 : clip_q;
		in_range = idx < CW'(WAVE_LEN);
		hit      = in_range && !pulser_mode && !clip_c
			&& (sample == (inverted ? '0 : FULL));
		win_ext  = (CW+1)'(slope_window);
		lo_c     = ({1'b0, idx} > win_ext) ? IDX_W'({1'b0, idx} - win_ext) : '0;
		n_c      = (IDX_W+1)'(idx) - (IDX_W+1)'(lo_c);
		wr_en    = in_fire && in_range;
		wr_addr  = {sel_q, (AW-1)'(idx)};
		wr_data  = inverted ? FULL - sample : sample;
		job_push = in_fire && last_sample;
		job.clipped    = clip_c || hit;
		job.clip_index = hit ? IDX_W'(idx) : (clip_c ? clip_pos_q : '0);
		job.fit_req    = hit ? (n_c >= 2) : (clip_c && fit_q);
		job.fit_lo     = hit ? lo_c : lo_q;
		job.fit_n      = hit ? n_c : n_q;
		job.wave_sel   = sel_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0; clip_q <= 1'b0; clip_pos_q <= '0;
			fit_q <= 1'b0; lo_q <= '0; n_q <= '0; sel_q <= 1'b0;
		end else if (in_fire) begin
			if (last_sample) begin
				index_q <= '0; clip_q <= 1'b0; fit_q <= 1'b0;
				sel_q   <= ~sel_q;
			end else begin
				index_q <= in_range ? idx + 1'b1 : idx;
				clip_q  <= job.clipped;
				if (hit) begin
					clip_pos_q <= IDX_W'(idx);
					fit_q      <= job.fit_req;
					lo_q       <= lo_c;
					n_q        <= n_c;
				end else if (first_sample) begin
					fit_q <= 1'b0;
				end
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/core/cdse_fit.sv */
`default_nettype none
module cdse_fit #(
	parameter int WAVE_LEN    = cdse_pkg::WAVE_LEN_DEF,
	parameter int SAMPLE_BITS = cdse_pkg::SAMPLE_BITS_DEF,
	parameter int AW          = $clog2(WAVE_LEN) + 1
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          job_valid,
	input  cdse_pkg::cdse_job_t          job,
	output logic                         job_pop,
	output logic [AW-1:0]                rd_addr,
	input  wire [SAMPLE_BITS-1:0]        rd_data,
	output logic                         res_valid,
	input  wire                          res_take,
	output logic                         clipped,
	output logic [cdse_pkg::IDX_W-1:0]   clip_index,
	output logic                         fit_done,
	output logic [cdse_pkg::IDX_W-1:0]   fit_start,
	output logic [cdse_pkg::IDX_W-1:0]   fit_end,
	output logic signed [cdse_pkg::SLOPE_W-1:0] slope_value,
	output logic                         slope_valid
);
	import cdse_pkg::*;
	localparam int SW = SAMPLE_BITS + IDX_W + 1;      // plain sum
	localparam int WW = SAMPLE_BITS + 2*IDX_W + 2;    // weighted sum
	localparam int NW = WW + 14;                      // numerator
	localparam int DW = 3*(IDX_W+1);                  // denominator
	localparam int QW = NW + 1;
	localparam int CNTW = $clog2(QW + 1);

	fit_state_t st_q, st_d;
	cdse_job_t  job_q;
	logic [IDX_W:0]  j_q;
	logic            rv_q;
	logic [IDX_W:0]  jr_q;
	logic [SW-1:0]   sum_q;
	logic [WW-1:0]   wsum_q;
	logic signed [WW+1:0] s2_q;
	logic [NW-1:0]   rem_num_q;
	logic [DW-1:0]   den_q;
	logic [NW:0]     part_q;
	logic [NW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            neg_q;
	logic [2:0]      mstep_q;

	logic [NW:0] trial;
	logic        out_busy;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			FIT_IDLE: if (job_valid) st_d = job.fit_req ? FIT_ACC : FIT_OUT;
			FIT_ACC:  if (!rv_q && j_q == job_q.fit_n) st_d = FIT_MUL;
			FIT_MUL:  if (mstep_q == 3'd3) st_d = FIT_DIV;
			FIT_DIV:  if (cnt_q == '0) st_d = FIT_OUT;
			FIT_OUT:  if (!out_busy) st_d = FIT_IDLE;
			default:  st_d = FIT_IDLE;
		endcase
	end

	always_comb begin
		out_busy = res_valid && !res_take;
		job_pop  = (st_q == FIT_IDLE) && job_valid;
		rd_addr  = {job_q.wave_sel, (AW-1)'(job_q.fit_lo + IDX_W'(j_q))};
		trial    = {part_q[NW-1:0], rem_num_q[NW-1]} - (NW+1)'(den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FIT_IDLE; res_valid <= 1'b0; rv_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (res_take) res_valid <= 1'b0;
			rv_q <= (st_q == FIT_ACC) && (j_q != job_q.fit_n);
			if (st_q == FIT_OUT && !out_busy) res_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			FIT_IDLE: begin
				job_q <= job; j_q <= '0; jr_q <= '0;
				sum_q <= '0; wsum_q <= '0; mstep_q <= '0;
			end
			FIT_ACC: begin
				if (j_q != job_q.fit_n) j_q <= j_q + 1'b1;
				if (rv_q) begin
					sum_q  <= sum_q + SW'(rd_data);
					wsum_q <= wsum_q + WW'(jr_q) * WW'(rd_data);
					jr_q   <= jr_q + 1'b1;
				end
			end
			FIT_MUL: begin
				mstep_q <= mstep_q + 1'b1;
				unique case (mstep_q)
					3'd0: begin
						s2_q  <= $signed({1'b0, wsum_q, 1'b0});
						den_q <= DW'(job_q.fit_n) * DW'(job_q.fit_n);
					end
					3'd1: begin
						s2_q  <= s2_q - $signed((WW+2)'((job_q.fit_n - 1'b1) * sum_q));
						den_q <= (den_q - 1'b1) * DW'(job_q.fit_n);
					end
					3'd2: begin
						neg_q     <= s2_q[WW+1];
						rem_num_q <= NW'(s2_q[WW+1] ? -s2_q : s2_q) * NW'(1536);
					end
					default: begin
						part_q <= '0; quo_q <= '0; cnt_q <= CNTW'(NW);
					end
				endcase
			end
			FIT_DIV: begin
				if (cnt_q != '0) begin
					cnt_q     <= cnt_q - 1'b1;
					rem_num_q <= rem_num_q << 1;
					if (!trial[NW]) begin
						part_q <= trial;
						quo_q  <= {quo_q[NW-2:0], 1'b1};
					end else begin
						part_q <= {part_q[NW-1:0], rem_num_q[NW-1]};
						quo_q  <= {quo_q[NW-2:0], 1'b0};
					end
				end
			end
			FIT_OUT: begin
				if (!out_busy) begin
					clipped    <= job_q.clipped;
					clip_index <= job_q.clip_index;
					fit_done   <= job_q.fit_req;
					fit_start  <= job_q.fit_req ? job_q.fit_lo : '0;
					fit_end    <= job_q.fit_req ? job_q.clip_index - 1'b1 : '0;
					slope_valid <= job_q.fit_req && !neg_q && (s2_q != '0);
					if (!job_q.fit_req) slope_value <= '0;
					else if (neg_q)
						slope_value <= (quo_q > NW'(1048576)) ? -21'sd1048576
							: -$signed(SLOPE_W'(quo_q));
					else
						slope_value <= (quo_q > NW'(1048575)) ? 21'sd1048575
							: $signed(SLOPE_W'(quo_q));
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* rtl/core/clip_detect_slope_estimator.sv */
`default_nettype none
// Clip detector with pre-clip slope fit. The front end takes one sample per
// cycle, writes the polarity-corrected value into a double-banked sample RAM
// and finds the first clipped sample. At the last sample of a waveform it
// pushes a job into a two-entry queue. The fit engine reads the fitted samples
// back one per cycle, forms the centered weighted sum, and divides by
// n(n^2-1)/12 with a one-bit-per-cycle divider. A fitted waveform reads back
// n samples (n up to slope_window); an unfitted one skips straight to output.
// Samples stream at one per cycle until the queue fills. Result values are
// signed with 8 fraction bits, truncated toward zero and saturated.
module clip_detect_slope_estimator #(
	parameter int WAVE_LEN    = cdse_pkg::WAVE_LEN_DEF,
	parameter int SAMPLE_BITS = cdse_pkg::SAMPLE_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire [SAMPLE_BITS-1:0]      sample,
	input  wire                        inverted,
	input  wire                        first_sample,
	input  wire                        last_sample,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire                        cfg_index,
	input  wire [cdse_pkg::WIN_W-1:0]  cfg_data,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic                       clipped,
	output logic [cdse_pkg::IDX_W-1:0] clip_index,
	output logic                       fit_done,
	output logic [cdse_pkg::IDX_W-1:0] fit_start,
	output logic [cdse_pkg::IDX_W-1:0] fit_end,
	output logic signed [cdse_pkg::SLOPE_W-1:0] slope_value,
	output logic                       slope_valid
);
	import cdse_pkg::*;
	localparam int AW = $clog2(WAVE_LEN) + 1;

	logic [WIN_W-1:0] window_q;
	logic             pulser_q;
	logic             in_fire, wr_en, job_push, job_pop;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic [SAMPLE_BITS-1:0] wr_data, rd_data;
	cdse_job_t        job_in;
	cdse_job_t        queue_q [2];
	logic [1:0]       count_q;
	logic             rd_ptr_q, wr_ptr_q;

	// One waveform may be in flight per RAM bank, so allow at most one
	// queued job plus the one being fitted.
	assign in_stall  = count_q[1];
	assign in_fire   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			pulser_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_SLOPE_WINDOW: window_q <= cfg_data;
				REG_PULSER_MODE:  pulser_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Count tracks jobs pushed but not yet fully delivered.
	logic done_pulse;
	assign done_pulse = out_valid && !out_stall;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; rd_ptr_q <= 1'b0; wr_ptr_q <= 1'b0;
		end else begin
			count_q <= count_q + 2'(job_push) - 2'(done_pulse);
			if (job_push) wr_ptr_q <= ~wr_ptr_q;
			if (job_pop)  rd_ptr_q <= ~rd_ptr_q;
		end
	end
	always_ff @(posedge clk) begin
		if (job_push) queue_q[wr_ptr_q] <= job_in;
	end

	logic pending;
	assign pending = (rd_ptr_q != wr_ptr_q);

	cdse_front #(.WAVE_LEN(WAVE_LEN), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk, .arst_n, .in_fire, .sample, .inverted, .first_sample, .last_sample,
		.slope_window(window_q), .pulser_mode(pulser_q),
		.wr_en, .wr_addr, .wr_data, .job_push, .job(job_in)
	);

	cdse_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(2**AW)) u_ram (
		.clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
		.raddr(rd_addr), .rdata(rd_data)
	);

	cdse_fit #(.WAVE_LEN(WAVE_LEN), .SAMPLE_BITS(SAMPLE_BITS)) u_fit (
		.clk, .arst_n, .job_valid(pending), .job(queue_q[rd_ptr_q]), .job_pop,
		.rd_addr, .rd_data, .res_valid(out_valid), .res_take(done_pulse),
		.clipped, .clip_index, .fit_done, .fit_start, .fit_end,
		.slope_value, .slope_valid
	);
endmodule
`default_nettype wire

/* rtl/core/cdse_checker.sv */
`default_nettype none
module cdse_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_stall,
	input wire       clipped,
	input wire       fit_done,
	input wire       slope_valid,
	input wire [8:0] clip_index,
	input wire [8:0] fit_start,
	input wire [8:0] fit_end
);
	a_fit_needs_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fit_done |-> clipped) else $error("fit without clip");
	a_valid_needs_fit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && slope_valid |-> fit_done) else $error("slope valid without fit");
	a_end_before_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fit_done |-> (fit_end + 9'd1 == clip_index) && (fit_start < clip_index))
		else $error("fit range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
endmodule

bind clip_detect_slope_estimator cdse_checker u_cdse_checker (
	.clk, .arst_n, .out_valid, .out_stall, .clipped, .fit_done, .slope_valid,
	.clip_index, .fit_start, .fit_end
);
`default_nettype wire

/* test/clip_detect_slope_estimator_tb.sv */
`timescale 1ns / 1ps

module clip_detect_slope_estimator_tb;
	import cdse_pkg::*;

	localparam int WAVE_LEN   = WAVE_LEN_DEF;
	localparam int FULL_SCALE = (1 << SAMPLE_BITS_DEF) - 1;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 700;

	// One waveform summary as the block reports it after the last sample.
	typedef struct {
		logic                      clipped;
		logic [IDX_W-1:0]          clip_index;
		logic                      fit_done;
		logic [IDX_W-1:0]          fit_start;
		logic [IDX_W-1:0]          fit_end;
		logic signed [SLOPE_W-1:0] slope_value;
		logic                      slope_valid;
	} wave_summary_t;

	// Tracks the clip search and slope fit of the waveform in flight and
	// holds the summaries that the block still owes.
	class clip_fit_scoreboard;
		logic [SAMPLE_BITS_DEF-1:0] corrected[WAVE_LEN];
		int                         wave_pos;
		bit                         clip_found;
		int                         clip_at;
		bit                         fitted;
		bit                         fit_positive;
		int                         fit_lo;
		logic signed [SLOPE_W-1:0]  fit_slope;
		int                         window;
		bit                         pulser;
		wave_summary_t              owed[$];
		int                         errors;

		function new();
			window = WINDOW_RESET;
			pulser = 0;
			errors = 0;
			restart_wave();
		endfunction

		function void restart_wave();
			wave_pos = 0;
			clip_found = 0;
			clip_at = 0;
			fitted = 0;
			fit_positive = 0;
			fit_lo = 0;
			fit_slope = '0;
		endfunction

		function void set_register(reg_index_t idx, logic [WIN_W-1:0] data);
			if (idx == REG_SLOPE_WINDOW)
				window = data;
			else
				pulser = data[0];
		endfunction

		// Least-squares slope of the samples just before the clip, scaled by
		// 256, truncated toward zero and saturated to the output range.
		function void fit_before(int clip);
			int     lo;
			int     n;
			longint sum;
			longint wsum;
			longint s2;
			longint q;
			lo = (clip > window) ? clip - window : 0;
			n = clip - lo;
			sum = 0;
			wsum = 0;
			if (n < 2)
				return;
			for (int j = 0; j < n; j++) begin
				sum += corrected[lo + j];
				wsum += longint'(j) * corrected[lo + j];
			end
			s2 = 2 * wsum - longint'(n - 1) * sum;
			q = (s2 * 1536) / (longint'(n) * (longint'(n) * n - 1));
			if (q > 1048575)
				q = 1048575;
			if (q < -1048576)
				q = -1048576;
			fit_slope = q[SLOPE_W-1:0];
			fitted = 1;
			fit_positive = s2 > 0;
			fit_lo = lo;
		endfunction

		function void note_input(logic [SAMPLE_BITS_DEF-1:0] s, bit inv, bit first, bit last);
			wave_summary_t w;
			if (first)
				restart_wave();
			// Samples past the end of the sample store are dropped.
			if (wave_pos < WAVE_LEN) begin
				corrected[wave_pos] = inv ? FULL_SCALE - s : s;
				if (!pulser && !clip_found && s == (inv ? 0 : FULL_SCALE)) begin
					clip_found = 1;
					clip_at = wave_pos;
					fit_before(wave_pos);
				end
				wave_pos++;
			end
			if (!last)
				return;
			w.clipped = clip_found;
			w.clip_index = clip_found ? clip_at[IDX_W-1:0] : '0;
			w.fit_done = fitted;
			w.fit_start = fitted ? fit_lo[IDX_W-1:0] : '0;
			w.fit_end = fitted ? IDX_W'(clip_at - 1) : '0;
			w.slope_value = fitted ? fit_slope : '0;
			w.slope_valid = fitted && fit_positive;
			owed.push_back(w);
			restart_wave();
		endfunction

		function void check_result(wave_summary_t got);
			wave_summary_t exp;
			if (owed.size() == 0) begin
				$error("summary with nothing owed");
				errors++;
				return;
			end
			exp = owed.pop_front();
			if (got.clipped !== exp.clipped) begin
				$error("clipped: expected %0d, got %0d", exp.clipped, got.clipped);
				errors++;
			end
			if (got.clip_index !== exp.clip_index) begin
				$error("clip_index: expected %0d, got %0d", exp.clip_index, got.clip_index);
				errors++;
			end
			if (got.fit_done !== exp.fit_done) begin
				$error("fit_done: expected %0d, got %0d", exp.fit_done, got.fit_done);
				errors++;
			end
			if (got.fit_start !== exp.fit_start) begin
				$error("fit_start: expected %0d, got %0d", exp.fit_start, got.fit_start);
				errors++;
			end
			if (got.fit_end !== exp.fit_end) begin
				$error("fit_end: expected %0d, got %0d", exp.fit_end, got.fit_end);
				errors++;
			end
			if (got.slope_value !== exp.slope_value) begin
				$error("slope_value: expected %0d, got %0d", exp.slope_value,
					got.slope_value);
				errors++;
			end
			if (got.slope_valid !== exp.slope_valid) begin
				$error("slope_valid: expected %0d, got %0d", exp.slope_valid,
					got.slope_valid);
				errors++;
			end
		endfunction
	endclass

	logic                       clk = 0;
	logic                       arst_n = 0;
	logic                       in_valid = 0;
	logic                       in_stall;
	logic [SAMPLE_BITS_DEF-1:0] sample = '0;
	logic                       inverted = 0;
	logic                       first_sample = 0;
	logic                       last_sample = 0;
	logic                       cfg_valid = 0;
	logic                       cfg_ready;
	logic                       cfg_index = 0;
	logic [WIN_W-1:0]           cfg_data = '0;
	logic                       out_valid;
	logic                       out_stall = 0;
	logic                       clipped;
	logic [IDX_W-1:0]           clip_index;
	logic                       fit_done;
	logic [IDX_W-1:0]           fit_start;
	logic [IDX_W-1:0]           fit_end;
	logic signed [SLOPE_W-1:0]  slope_value;
	logic                       slope_valid;

	clip_fit_scoreboard board = new();
	// While calm is set neither side inserts idle cycles.
	bit calm = 0;
	int sent = 0;
	int cycles = 0;

	clip_detect_slope_estimator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample(sample), .inverted(inverted),
		.first_sample(first_sample), .last_sample(last_sample),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.clipped(clipped), .clip_index(clip_index), .fit_done(fit_done),
		.fit_start(fit_start), .fit_end(fit_end),
		.slope_value(slope_value), .slope_valid(slope_valid)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// The run is bounded; a hung handshake ends in failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// The receiver stalls at random except during the calm phase.
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 22);
	end

	// Every summary accepted at an edge goes to the scoreboard.
	always @(posedge clk) begin
		wave_summary_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.clipped = clipped;
			got.clip_index = clip_index;
			got.fit_done = fit_done;
			got.fit_start = fit_start;
			got.fit_end = fit_end;
			got.slope_value = slope_value;
			got.slope_valid = slope_valid;
			board.check_result(got);
		end
	end

	// Offers one item and holds it until the block takes it. Outside the calm phase,
	// idle cycles are at random inserted in front of the item so that gaps land on every phase.
	task automatic send_item(logic [SAMPLE_BITS_DEF-1:0] s, bit inv, bit first, bit last);
		if (!calm && $urandom_range(0, 99) < 22) begin
			in_valid <= 0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < 40);
		end
		in_valid <= 1;
		sample <= s;
		inverted <= inv;
		first_sample <= first;
		last_sample <= last;
		do
			@(posedge clk);
		while (in_stall);
		board.note_input(s, inv, first, last);
		sent++;
	endtask

	// Ends in the cycle after the write so that back-to-back writes never
	// collide on the valid line.
	task automatic write_register(reg_index_t idx, logic [WIN_W-1:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 0;
		board.set_register(idx, data);
		@(posedge clk);
	endtask

	// Waits for every owed summary, then lets the fit engine run dry so that
	// a register write never lands on a waveform still in progress.
	task automatic drain();
		in_valid <= 0;
		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sends one waveform whose polarity-corrected values follow a noisy ramp
	// and that clips at clip_at (no clip if clip_at is negative or past the
	// end). With mix set, each sample picks its own polarity.
	task automatic send_wave(int len, int clip_at, bit inv, bit mix, int base, int step,
			int noise, bit drop_first);
		int  y;
		bit  pol;
		logic [SAMPLE_BITS_DEF-1:0] s;
		for (int i = 0; i < len; i++) begin
			pol = mix ? $urandom_range(0, 1) : inv;
			if (i == clip_at) begin
				s = pol ? 0 : FULL_SCALE;
			end else if (i > clip_at && clip_at >= 0) begin
				s = $urandom_range(0, FULL_SCALE);
			end else begin
				y = base + step * i + $urandom_range(0, 2 * noise) - noise;
				if (y < 1)
					y = 1;
				if (y > FULL_SCALE - 1)
					y = FULL_SCALE - 1;
				s = pol ? FULL_SCALE - y : y;
			end
			send_item(s, pol, (i == 0) && !drop_first, i == len - 1);
		end
	endtask

	// A mix of well-formed ramps with random content and pure noise items.
	task automatic random_waves(int count);
		int goal;
		int len;
		int clip_at;
		goal = sent + count;
		while (sent < goal) begin
			if ($urandom_range(0, 99) < 15) begin
				send_item($urandom_range(0, 99) < 10 ? ($urandom_range(0, 1) ? FULL_SCALE : 0)
					: $urandom_range(0, FULL_SCALE), $urandom_range(0, 1),
					$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
			end else begin
				len = ($urandom_range(0, 99) < 3) ? $urandom_range(400, 530)
					: $urandom_range(1, 40);
				clip_at = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, len);
				send_wave(len, clip_at, $urandom_range(0, 1), $urandom_range(0, 9) == 0,
					$urandom_range(0, FULL_SCALE), $signed($urandom_range(0, 400)) - 200,
					$urandom_range(0, 60), $urandom_range(0, 9) == 0);
			end
		end
		// Close any waveform that a noise item left open.
		send_item($urandom_range(1, FULL_SCALE - 1), 0, 0, 1);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part under the reset settings of the registers.
		send_item(FULL_SCALE, 0, 1, 1);          // one-sample waveform, clip at index 0
		send_item(0, 1, 1, 1);                   // inverted clip at index 0
		send_wave(3, 1, 0, 0, 100, 10, 0, 0);    // clip at index 1: too few to fit
		send_wave(6, 5, 0, 0, 0, 819, 0, 0);     // steep rise from zero
		send_wave(6, 5, 1, 0, 4000, -700, 0, 0); // inverted, falling corrected values
		send_wave(5, -1, 0, 0, 2000, 0, 0, 0);   // no clip at all
		send_wave(4, 3, 0, 1, 1000, 5, 3, 1);    // mixed polarity, missing first flag
		drain();

		// Smallest legal window, with the steepest possible two-point slope.
		write_register(REG_SLOPE_WINDOW, 2);
		send_wave(3, 2, 0, 0, 1, 4093, 0, 0);
		send_wave(3, 2, 1, 0, 4094, -4093, 0, 0);
		random_waves(80);
		drain();

		// Windows below two never fit.
		write_register(REG_SLOPE_WINDOW, 0);
		random_waves(30);
		drain();
		write_register(REG_SLOPE_WINDOW, 1);
		random_waves(30);
		drain();

		// Widest window: a nearly flat run clipped at the last stored index
		// fits all 511 samples before it, and its slope can be positive yet
		// truncate to zero. The waveform also runs past the sample store.
		write_register(REG_SLOPE_WINDOW, 511);
		send_wave(530, 511, 0, 0, 2000, 0, 1, 0);
		random_waves(80);
		drain();

		// Pulser mode suppresses every clip.
		write_register(REG_PULSER_MODE, 1);
		random_waves(60);
		drain();
		write_register(REG_PULSER_MODE, 0);

		// A phase with no idle cycles on either side.
		calm = 1;
		write_register(REG_SLOPE_WINDOW, 16);
		random_waves(120);
		drain();
		calm = 0;

		for (int k = 0; k < 3; k++) begin
			write_register(REG_SLOPE_WINDOW, $urandom_range(2, 64));
			random_waves(50);
			drain();
		end

		if (board.errors == 0 && board.owed.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
